/* hw/rtl/sfr_pkg.sv */
// shared types and constants for the spi frame receiver
// used by sfr_ctrl and spi_frame_receiver_checksum_ack; no dependencies
package sfr_pkg;

  // word and field widths
  localparam int WordW   = 16;
  localparam int KindW   = 2;
  localparam int IndexW  = 8;
  localparam int LenW    = 8;
  localparam int PosW    = 9;
  localparam int CfgIdxW = 1;

  // default buffer depth
  localparam int BufferDepth = 256;

  // header bit that marks a transmit header
  localparam int DirBit = 15;

  // saturation limit of the write position
  localparam logic [PosW-1:0] PosMax = '1;

  // request kinds
  localparam logic [KindW-1:0] KindWord    = 2'd0;
  localparam logic [KindW-1:0] KindRelease = 2'd1;
  localparam logic [KindW-1:0] KindRead    = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAck  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgNack = 1'd1;

  // configuration reset values
  localparam logic [WordW-1:0] AckReset  = 16'd1;
  localparam logic [WordW-1:0] NackReset = 16'd2;

  // per-request result, without the buffer read data
  typedef struct packed {
    logic             tx_valid;
    logic [WordW-1:0] tx_word;
    logic             frame_done;
    logic             frame_ok;
    logic             message_pending;
  } res_t;

  // buffer write request
  typedef struct packed {
    logic             en;
    logic [PosW-1:0]  pos;
    logic [WordW-1:0] data;
  } wr_t;

endpackage

/* hw/rtl/sfr_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module sfr_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sfr_ctrl.sv */
// frame tracking: header, data count, running sum, checksum check and ack/nack reply
// depends on sfr_pkg; drives the buffer write request of the top level
module sfr_ctrl #(
  parameter int BufferDepth = sfr_pkg::BufferDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [sfr_pkg::KindW-1:0]  kind_i,
  input  logic [sfr_pkg::WordW-1:0]  rx_word_i,
  input  logic [sfr_pkg::WordW-1:0]  ack_code_i,
  input  logic [sfr_pkg::WordW-1:0]  nack_code_i,
  output sfr_pkg::res_t              res_o,
  output sfr_pkg::wr_t               wr_o
);

  logic                        receiving_q, receiving_d;
  logic                        ack_sent_q, ack_sent_d;
  logic                        pending_q, pending_d;
  logic [sfr_pkg::LenW-1:0]    words_left_q, words_left_d;
  logic [sfr_pkg::PosW-1:0]    wpos_q, wpos_d;
  logic [sfr_pkg::WordW-1:0]   sum_q, sum_d;
  logic                        pos_in_range;
  logic [sfr_pkg::PosW-1:0]    wpos_inc;

  assign pos_in_range = int'(wpos_q) < BufferDepth;
  assign wpos_inc     = (wpos_q != sfr_pkg::PosMax) ? wpos_q + 1'b1 : wpos_q;

  // next state and result of one request
  always_comb begin
    receiving_d  = receiving_q;
    ack_sent_d   = ack_sent_q;
    pending_d    = pending_q;
    words_left_d = words_left_q;
    wpos_d       = wpos_q;
    sum_d        = sum_q;
    res_o        = '0;
    wr_o         = '0;
    wr_o.data    = rx_word_i;
    wr_o.pos     = wpos_q;

    unique case (kind_i)
      sfr_pkg::KindWord: begin
        if (ack_sent_q || pending_q) begin
          // discard while busy
          ack_sent_d  = 1'b0;
          receiving_d = 1'b0;
        end else if (receiving_q) begin
          if (words_left_q != '0) begin
            // data word
            wr_o.en      = pos_in_range;
            sum_d        = sum_q + rx_word_i;
            words_left_d = words_left_q - 1'b1;
          end else begin
            // checksum word
            res_o.frame_done = 1'b1;
            res_o.tx_valid   = 1'b1;
            if (sum_q + 16'd1 == rx_word_i) begin
              res_o.frame_ok = 1'b1;
              res_o.tx_word  = ack_code_i;
              pending_d      = 1'b1;
            end else begin
              res_o.tx_word  = nack_code_i;
            end
            ack_sent_d = 1'b1;
          end
          wpos_d = wpos_inc;
        end else begin
          // idle: look for a receive header
          wpos_d = '0;
          if (!rx_word_i[sfr_pkg::DirBit]) begin
            words_left_d = rx_word_i[sfr_pkg::LenW-1:0];
            receiving_d  = 1'b1;
            wr_o.en      = 1'b1;
            wr_o.pos     = '0;
            wpos_d       = sfr_pkg::PosW'(1);
            sum_d        = rx_word_i;
          end
        end
      end
      sfr_pkg::KindRelease: begin
        pending_d = 1'b0;
      end
      default: begin
      end
    endcase

    res_o.message_pending = pending_d;
    wr_o.en               = wr_o.en & accept_i;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q  <= 1'b0;
      ack_sent_q   <= 1'b0;
      pending_q    <= 1'b0;
      words_left_q <= '0;
      wpos_q       <= '0;
      sum_q        <= '0;
    end else if (accept_i) begin
      receiving_q  <= receiving_d;
      ack_sent_q   <= ack_sent_d;
      pending_q    <= pending_d;
      words_left_q <= words_left_d;
      wpos_q       <= wpos_d;
      sum_q        <= sum_d;
    end
  end

  // a matched checksum leaves a message pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.frame_ok |=> pending_q && ack_sent_q)
    else $error("matched frame did not set pending");

  // no buffer write while a reply or message is outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> !ack_sent_q && !pending_q)
    else $error("buffer write while busy");

endmodule

/* hw/rtl/spi_frame_receiver_checksum_ack.sv */
// top level of the spi frame receiver: config registers, buffer ram,
// result pipeline; depends on sfr_pkg, sfr_ctrl and sfr_ram
//
// usage
// - input channel (in_valid_i / in_stall_o) carries one request per word:
//   a received spi word, a release of the pending message, or a buffer read
// - output channel (out_valid_o / out_stall_i) returns exactly one result
//   per request, in order
// - config port writes ack_code (index 0) and nack_code (index 1); the user
//   writes them only while the block is idle, which the block does not enforce
// - from acceptance to out_valid_o a result passes the stage aligned with
//   the buffer ram read and then the output register
// - throughput is one request per cycle while in_stall_o is low; the frame
//   state updates at acceptance and the single ram port pair (one write,
//   one read) is used at most once per request, so no interlock is needed
// - when the receiver stalls, the output register and the stage before it
//   hold their results and in_stall_o rises only once both are full
// - reset clears frame state and the pipeline and restores the ack/nack
//   codes; the buffer has no clearing pass and reads of unwritten entries
//   return undefined data
module spi_frame_receiver_checksum_ack #(
  parameter int BufferDepth = sfr_pkg::BufferDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfr_pkg::WordW-1:0]   cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sfr_pkg::KindW-1:0]   kind_i,
  input  logic [sfr_pkg::WordW-1:0]   rx_word_i,
  input  logic [sfr_pkg::IndexW-1:0]  read_index_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        tx_valid_o,
  output logic [sfr_pkg::WordW-1:0]   tx_word_o,
  output logic                        frame_done_o,
  output logic                        frame_ok_o,
  output logic                        message_pending_o,
  output logic [sfr_pkg::WordW-1:0]   read_word_o
);

  localparam int AddrW = $clog2(BufferDepth);

  logic [sfr_pkg::WordW-1:0] ack_q, nack_q;
  logic                      accept;
  sfr_pkg::res_t             res;
  sfr_pkg::wr_t              wr;
  logic                      rd_en;
  logic [sfr_pkg::WordW-1:0] ram_rdata;

  logic                      s1_valid_q;
  sfr_pkg::res_t             s1_res_q;
  logic                      s1_rd_q;
  logic                      s1_move;

  logic                      out_valid_q;
  sfr_pkg::res_t             out_res_q;
  logic [sfr_pkg::WordW-1:0] out_rdata_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_q  <= sfr_pkg::AckReset;
      nack_q <= sfr_pkg::NackReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfr_pkg::CfgAck:  ack_q  <= cfg_wdata_i;
        sfr_pkg::CfgNack: nack_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign s1_move    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_move;
  assign accept     = in_valid_i && !in_stall_o;

  // frame control
  sfr_ctrl #(
    .BufferDepth(BufferDepth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (kind_i),
    .rx_word_i  (rx_word_i),
    .ack_code_i (ack_q),
    .nack_code_i(nack_q),
    .res_o      (res),
    .wr_o       (wr)
  );

  // buffer read request, out of range reads return zero
  assign rd_en = (kind_i == sfr_pkg::KindRead) && (int'(read_index_i) < BufferDepth);

  sfr_ram #(
    .Width(sfr_pkg::WordW),
    .Depth(BufferDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr.en),
    .waddr_i(AddrW'(wr.pos)),
    .wdata_i(wr.data),
    .re_i   (accept && rd_en),
    .raddr_i(AddrW'(read_index_i)),
    .rdata_o(ram_rdata)
  );

  // stage aligned with the ram read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept || s1_move) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
      s1_rd_q  <= rd_en;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_res_q   <= s1_res_q;
      out_rdata_q <= s1_rd_q ? ram_rdata : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign tx_valid_o        = out_res_q.tx_valid;
  assign tx_word_o         = out_res_q.tx_word;
  assign frame_done_o      = out_res_q.frame_done;
  assign frame_ok_o        = out_res_q.frame_ok;
  assign message_pending_o = out_res_q.message_pending;
  assign read_word_o       = out_rdata_q;

  // stall only with both stages full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with room in the pipeline");

  // a held result is not lost while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && out_valid_q)
    else $error("result dropped during stall");

endmodule
